// File: design/hierarchical_timing_wheel_macros.svh
// Assertion helpers used by the hierarchical_timing_wheel module.
`ifndef HIERARCHICAL_TIMING_WHEEL_MACROS_SVH
`define HIERARCHICAL_TIMING_WHEEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/htw_pkg.sv
package htw_pkg;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [2:0] KIND_ASSIGNED = 3'd0;
    localparam logic [2:0] KIND_EXPIRED  = 3'd1;
    localparam logic [2:0] KIND_FULL     = 3'd2;
    localparam logic [2:0] KIND_BAD      = 3'd3;
    localparam logic [2:0] KIND_DONE     = 3'd4;

    localparam int ENTRY_W    = 6;
    localparam logic [ENTRY_W-1:0] NIL = 6'd63;
    localparam int NUM_LEVELS = 4;
    localparam int RES_CAP    = 32;
    localparam int CNT_W      = 6;

    typedef logic [ENTRY_W-1:0] t_entry;

endpackage

// File: design/hierarchical_timing_wheel.sv
// An expired-at-once, pool-full or bad-handle result is on the ports in the cycle after
// acceptance; add passes the append read and write states, restart the unlink ones first,
// then their result follows. A tick fires the near slot, steps the tick, re-places a due
// level slot's timers, fires the new near slot, gives a done result. One transaction
// at a time; the next is accepted while the last result shows. Results cannot be stalled.
// After reset the slot RAM is swept to empty, one slot per cycle, with busy held high.
module hierarchical_timing_wheel #(
    parameter int NEAR_BITS  = 8,
    parameter int LEVEL_BITS = 6,
    parameter int NUM_TIMERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_tag,
    input  logic signed [31:0] i_delay,
    input  logic [4:0]  i_handle,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [4:0]  o_handle_res,
    output logic [31:0] o_tag_res,
    output logic [31:0] o_now,
    output logic        o_last
);

`include "hierarchical_timing_wheel_macros.svh"

    localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
    localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
    localparam int SLOT_DEPTH  = NEAR_SLOTS + htw_pkg::NUM_LEVELS * LEVEL_SLOTS;
    localparam int SLOT_W      = $clog2(SLOT_DEPTH);
    localparam int EW          = htw_pkg::ENTRY_W;
    localparam int EIW         = $clog2(NUM_TIMERS);
    localparam int GW          = $clog2(NUM_TIMERS + 1);
    localparam int CW          = htw_pkg::CNT_W;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_UN_RD   = 4'd2;
    localparam logic [3:0] S_UN_WR   = 4'd3;
    localparam logic [3:0] S_AP_RD   = 4'd4;
    localparam logic [3:0] S_AP_WR   = 4'd5;
    localparam logic [3:0] S_FR_RD   = 4'd6;
    localparam logic [3:0] S_FR_HD   = 4'd7;
    localparam logic [3:0] S_FR_WALK = 4'd8;
    localparam logic [3:0] S_ADV     = 4'd9;
    localparam logic [3:0] S_CS_RD   = 4'd10;
    localparam logic [3:0] S_CS_HD   = 4'd11;
    localparam logic [3:0] S_CS_WALK = 4'd12;

    logic [3:0]         r_state, n_state;
    logic [SLOT_W-1:0]  r_clr, n_clr;
    logic [31:0]        r_tick, n_tick;
    logic [31:0]        r_now, n_now;
    htw_pkg::t_entry    r_e, n_e;
    htw_pkg::t_entry    r_nx, n_nx;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [GW-1:0]      r_guard, n_guard;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_phase, n_phase;
    logic               r_mode, n_mode;

    logic               r_valid, n_valid;
    logic [2:0]         r_kind, n_kind;
    logic [4:0]         r_hres, n_hres;
    logic [31:0]        r_tres, n_tres;
    logic [31:0]        r_onow, n_onow;
    logic               r_last, n_last;

    htw_pkg::t_entry    r_next [NUM_TIMERS];
    htw_pkg::t_entry    r_prev [NUM_TIMERS];
    logic [31:0]        r_expiry [NUM_TIMERS];
    logic [30:0]        r_delay [NUM_TIMERS];
    logic [31:0]        r_tagm [NUM_TIMERS];
    logic [SLOT_W-1:0]  r_slot_of [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_armed;

    logic               nxa_we, nxb_we, prv_we, slt_we, exp_we, add_we, arm_set, arm_clr;
    logic [EIW-1:0]     nxa_addr, nxb_addr, prv_addr, slt_addr, exp_addr, add_addr, arm_addr;
    htw_pkg::t_entry    nxa_data, nxb_data, prv_data;
    logic [SLOT_W-1:0]  slt_data;
    logic [31:0]        exp_data;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
    logic [2*EW-1:0]    ram_wdata, ram_rdata;
    htw_pkg::t_entry    rd_hd, rd_tl;

    logic [EIW-1:0]     e_idx;
    logic [SLOT_W-1:0]  calc_slot;
    logic               free_found;
    logic [EIW-1:0]     free_idx;
    htw_pkg::t_entry    h_ext;
    logic               cs_hit;
    logic [SLOT_W-1:0]  cs_slot;

    assign e_idx = r_e[EIW-1:0];
    assign rd_hd = ram_rdata[2*EW-1:EW];
    assign rd_tl = ram_rdata[EW-1:0];
    assign h_ext = EW'(i_handle);

    htw_ram #(
        .WIDTH(2 * EW),
        .DEPTH(SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    htw_slot_calc #(
        .NEAR_BITS (NEAR_BITS),
        .LEVEL_BITS(LEVEL_BITS),
        .SLOT_W    (SLOT_W)
    ) u_slot_calc (
        .i_expiry(r_expiry[e_idx]),
        .i_now   (r_tick),
        .o_slot  (calc_slot)
    );

    always_comb begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_armed[i]) begin
                free_found = 1'b1;
                free_idx = EIW'(i);
            end
        end
    end

    always_comb begin
        logic [31:0] ct;
        logic [31:0] shifted;
        logic stop;
        int sh;
        ct = r_tick + 32'd1;
        stop = 1'b0;
        shifted = '0;
        sh = 0;
        cs_hit = 1'b0;
        cs_slot = '0;
        if (ct == 32'd0) begin
            cs_hit = 1'b1;
            cs_slot = SLOT_W'(NEAR_SLOTS + 3 * LEVEL_SLOTS);
        end else begin
            for (int i = 0; i < htw_pkg::NUM_LEVELS; i++) begin
                sh = NEAR_BITS + i * LEVEL_BITS;
                if (!stop) begin
                    if (sh >= 32 || (ct & ((32'd1 << sh) - 32'd1)) != 32'd0) begin
                        stop = 1'b1;
                    end else begin
                        shifted = ct >> sh;
                        if (shifted[LEVEL_BITS-1:0] != '0) begin
                            cs_hit = 1'b1;
                            cs_slot = SLOT_W'(NEAR_SLOTS + i * LEVEL_SLOTS)
                                    + SLOT_W'(shifted[LEVEL_BITS-1:0]);
                            stop = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_tick = r_tick;
        n_now = r_now;
        n_e = r_e;
        n_nx = r_nx;
        n_slot = r_slot;
        n_guard = r_guard;
        n_cnt = r_cnt;
        n_phase = r_phase;
        n_mode = r_mode;
        n_valid = 1'b0;
        n_kind = r_kind;
        n_hres = r_hres;
        n_tres = r_tres;
        n_onow = r_onow;
        n_last = 1'b0;
        nxa_we = 1'b0; nxa_addr = '0; nxa_data = htw_pkg::NIL;
        nxb_we = 1'b0; nxb_addr = '0; nxb_data = htw_pkg::NIL;
        prv_we = 1'b0; prv_addr = '0; prv_data = htw_pkg::NIL;
        slt_we = 1'b0; slt_addr = '0; slt_data = '0;
        exp_we = 1'b0; exp_addr = '0; exp_data = '0;
        add_we = 1'b0; add_addr = '0;
        arm_set = 1'b0; arm_clr = 1'b0; arm_addr = '0;
        ram_we = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = {htw_pkg::NIL, htw_pkg::NIL};
        ram_raddr = r_slot;
        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                ram_waddr = r_clr;
                n_clr = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_W'(SLOT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_operation)
                        htw_pkg::OP_ADD: begin
                            if (i_delay <= 32'sd0) begin
                                n_valid = 1'b1; n_last = 1'b1;
                                n_kind = htw_pkg::KIND_EXPIRED;
                                n_hres = '0; n_tres = i_tag; n_onow = r_tick;
                            end else if (!free_found) begin
                                n_valid = 1'b1; n_last = 1'b1;
                                n_kind = htw_pkg::KIND_FULL;
                                n_hres = '0; n_tres = '0; n_onow = r_tick;
                            end else begin
                                arm_set = 1'b1; arm_addr = free_idx;
                                add_we = 1'b1; add_addr = free_idx;
                                exp_we = 1'b1; exp_addr = free_idx;
                                exp_data = r_tick + $unsigned(i_delay);
                                n_e = EW'(free_idx);
                                n_mode = 1'b0;
                                n_state = S_AP_RD;
                            end
                        end
                        htw_pkg::OP_RESTART: begin
                            if (h_ext >= EW'(NUM_TIMERS) || !r_armed[h_ext[EIW-1:0]]) begin
                                n_valid = 1'b1; n_last = 1'b1;
                                n_kind = htw_pkg::KIND_BAD;
                                n_hres = i_handle; n_tres = '0; n_onow = r_tick;
                            end else begin
                                n_e = h_ext;
                                n_mode = 1'b0;
                                n_state = S_UN_RD;
                            end
                        end
                        htw_pkg::OP_TICK: begin
                            n_now = r_tick + 32'd1;
                            n_phase = 1'b0;
                            n_mode = 1'b0;
                            n_cnt = '0;
                            n_state = S_FR_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UN_RD: begin
                ram_raddr = r_slot_of[e_idx];
                n_slot = r_slot_of[e_idx];
                n_state = S_UN_WR;
            end
            S_UN_WR: begin
                if (r_prev[e_idx] < EW'(NUM_TIMERS)) begin
                    nxa_we = 1'b1;
                    nxa_addr = r_prev[e_idx][EIW-1:0];
                    nxa_data = r_next[e_idx];
                end
                if (r_next[e_idx] < EW'(NUM_TIMERS)) begin
                    prv_we = 1'b1;
                    prv_addr = r_next[e_idx][EIW-1:0];
                    prv_data = r_prev[e_idx];
                end
                ram_we = 1'b1;
                ram_wdata = {(r_prev[e_idx] < EW'(NUM_TIMERS)) ? rd_hd : r_next[e_idx],
                             (r_next[e_idx] < EW'(NUM_TIMERS)) ? rd_tl : r_prev[e_idx]};
                exp_we = 1'b1; exp_addr = e_idx;
                exp_data = r_tick + {1'b0, r_delay[e_idx]};
                n_state = S_AP_RD;
            end
            S_AP_RD: begin
                ram_raddr = calc_slot;
                n_slot = calc_slot;
                n_state = S_AP_WR;
            end
            S_AP_WR: begin
                slt_we = 1'b1; slt_addr = e_idx; slt_data = r_slot;
                nxa_we = 1'b1; nxa_addr = e_idx; nxa_data = htw_pkg::NIL;
                prv_we = 1'b1; prv_addr = e_idx; prv_data = rd_tl;
                ram_we = 1'b1;
                if (rd_tl < EW'(NUM_TIMERS)) begin
                    nxb_we = 1'b1; nxb_addr = rd_tl[EIW-1:0]; nxb_data = r_e;
                    ram_wdata = {rd_hd, r_e};
                end else begin
                    ram_wdata = {r_e, r_e};
                end
                if (r_mode) begin
                    n_e = r_nx;
                    n_guard = r_guard + GW'(1);
                    n_state = S_CS_WALK;
                end else begin
                    n_valid = 1'b1; n_last = 1'b1;
                    n_kind = htw_pkg::KIND_ASSIGNED;
                    n_hres = r_e[4:0]; n_tres = r_tagm[e_idx]; n_onow = r_tick;
                    n_state = S_IDLE;
                end
            end
            S_FR_RD: begin
                ram_raddr = SLOT_W'(r_tick[NEAR_BITS-1:0]);
                n_slot = SLOT_W'(r_tick[NEAR_BITS-1:0]);
                n_state = S_FR_HD;
            end
            S_FR_HD: begin
                ram_we = 1'b1;
                n_e = rd_hd;
                n_guard = '0;
                n_state = S_FR_WALK;
            end
            S_FR_WALK: begin
                if (r_e < EW'(NUM_TIMERS) && r_guard < GW'(NUM_TIMERS)
                    && r_cnt < CW'(htw_pkg::RES_CAP)) begin
                    n_valid = 1'b1;
                    n_kind = htw_pkg::KIND_EXPIRED;
                    n_hres = r_e[4:0]; n_tres = r_tagm[e_idx]; n_onow = r_now;
                    arm_clr = 1'b1; arm_addr = e_idx;
                    n_e = r_next[e_idx];
                    n_guard = r_guard + GW'(1);
                    n_cnt = r_cnt + CW'(1);
                end else if (!r_phase) begin
                    n_state = S_ADV;
                end else begin
                    n_valid = 1'b1; n_last = 1'b1;
                    n_kind = htw_pkg::KIND_DONE;
                    n_hres = '0; n_tres = '0; n_onow = r_now;
                    n_state = S_IDLE;
                end
            end
            S_ADV: begin
                n_tick = r_tick + 32'd1;
                if (cs_hit) begin
                    n_slot = cs_slot;
                    n_state = S_CS_RD;
                end else begin
                    n_phase = 1'b1;
                    n_state = S_FR_RD;
                end
            end
            S_CS_RD: begin
                n_state = S_CS_HD;
            end
            S_CS_HD: begin
                ram_we = 1'b1;
                n_e = rd_hd;
                n_guard = '0;
                n_mode = 1'b1;
                n_state = S_CS_WALK;
            end
            S_CS_WALK: begin
                if (r_e < EW'(NUM_TIMERS) && r_guard < GW'(NUM_TIMERS)) begin
                    n_nx = r_next[e_idx];
                    n_state = S_AP_RD;
                end else begin
                    n_phase = 1'b1;
                    n_mode = 1'b0;
                    n_state = S_FR_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_tick <= '0;
            r_armed <= '0;
            r_valid <= 1'b0;
            r_last <= 1'b0;
            r_phase <= 1'b0;
            r_mode <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_tick <= n_tick;
            r_valid <= n_valid;
            r_last <= n_last;
            r_phase <= n_phase;
            r_mode <= n_mode;
            if (arm_set) begin
                r_armed[arm_addr] <= 1'b1;
            end
            if (arm_clr) begin
                r_armed[arm_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        r_e <= n_e;
        r_nx <= n_nx;
        r_slot <= n_slot;
        r_guard <= n_guard;
        r_cnt <= n_cnt;
        r_kind <= n_kind;
        r_hres <= n_hres;
        r_tres <= n_tres;
        r_onow <= n_onow;
        if (nxa_we) begin
            r_next[nxa_addr] <= nxa_data;
        end
        if (nxb_we) begin
            r_next[nxb_addr] <= nxb_data;
        end
        if (prv_we) begin
            r_prev[prv_addr] <= prv_data;
        end
        if (slt_we) begin
            r_slot_of[slt_addr] <= slt_data;
        end
        if (exp_we) begin
            r_expiry[exp_addr] <= exp_data;
        end
        if (add_we) begin
            r_tagm[add_addr] <= i_tag;
            r_delay[add_addr] <= i_delay[30:0];
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_handle_res = r_hres;
    assign o_tag_res    = r_tres;
    assign o_now        = r_onow;
    assign o_last       = r_last;

    `HTW_ASSERT_NOW(a_last_has_valid, o_last, o_valid, "Last flag without a result strobe.")
    `HTW_ASSERT_NOW(a_quiet_in_clear, r_state == S_CLR, !o_valid, "Result during slot sweep.")
    `HTW_ASSERT_NEXT(a_tick_goes_busy, start && !busy && i_operation == htw_pkg::OP_TICK,
        busy, "Tick transaction did not start the sequencer.")
    `HTW_ASSERT_NOW(a_done_is_last, o_valid && o_kind == htw_pkg::KIND_DONE, o_last,
        "Tick done result is not marked last.")

endmodule

// File: design/htw_ram.sv
module htw_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/htw_slot_calc.sv
module htw_slot_calc #(
    parameter int NEAR_BITS  = 8,
    parameter int LEVEL_BITS = 6,
    parameter int SLOT_W     = 9
) (
    input  logic [31:0]       i_expiry,
    input  logic [31:0]       i_now,
    output logic [SLOT_W-1:0] o_slot
);

    localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
    localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
    localparam logic [31:0] NEAR_MASK = 32'(NEAR_SLOTS - 1);

    always_comb begin
        int  lvl;
        int  w;
        int  sh;
        logic found;
        logic [31:0] shifted;
        lvl = 3;
        w = 0;
        sh = 0;
        found = 1'b0;
        shifted = '0;
        o_slot = '0;
        if ((i_expiry | NEAR_MASK) == (i_now | NEAR_MASK)) begin
            o_slot = SLOT_W'(i_expiry & NEAR_MASK);
        end else begin
            for (int i = 0; i < 3; i++) begin
                w = NEAR_BITS + LEVEL_BITS * (i + 1);
                if (!found && (w >= 32 || (i_expiry >> w) == (i_now >> w))) begin
                    found = 1'b1;
                    lvl = i;
                end
            end
            sh = NEAR_BITS + lvl * LEVEL_BITS;
            shifted = (sh >= 32) ? 32'd0 : (i_expiry >> sh);
            o_slot = SLOT_W'(NEAR_SLOTS + lvl * LEVEL_SLOTS)
                   + SLOT_W'(shifted[LEVEL_BITS-1:0]);
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] tag;
        logic [31:0] delay;
        logic [4:0]  handle;
    } t_timer_cmd;

    typedef struct {
        logic [2:0]  kind;
        logic [4:0]  handle;
        logic [31:0] tag;
        logic [31:0] now;
        logic        last;
    } t_wheel_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [31:0] i_tag;
    logic signed [31:0] i_delay;
    logic [4:0]  i_handle;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [4:0]  o_handle_res;
    logic [31:0] o_tag_res;
    logic [31:0] o_now;
    logic        o_last;

    hierarchical_timing_wheel DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_tag(i_tag), .i_delay(i_delay),
        .i_handle(i_handle), .o_valid(o_valid), .o_kind(o_kind),
        .o_handle_res(o_handle_res), .o_tag_res(o_tag_res), .o_now(o_now),
        .o_last(o_last)
    );

    t_timer_cmd   cmd_q[$];
    t_wheel_event event_q[$];
    int           errors = 0;
    int           gap = 0;
    int           cycles = 0;
    bit           fill_done = 0;

    bit [31:0] m_now;
    bit [5:0]  m_near_hd[256];
    bit [5:0]  m_near_tl[256];
    bit [5:0]  m_lvl_hd[256];
    bit [5:0]  m_lvl_tl[256];
    bit [5:0]  m_next[32];
    bit [5:0]  m_prev[32];
    bit [31:0] m_expiry[32];
    bit [31:0] m_delay[32];
    bit [31:0] m_tag[32];
    int        m_slot[32];
    bit        m_armed[32];

    function automatic bit [5:0] slot_head(int s);
        return (s < 256) ? m_near_hd[s] : m_lvl_hd[s - 256];
    endfunction

    function automatic bit [5:0] slot_tail(int s);
        return (s < 256) ? m_near_tl[s] : m_lvl_tl[s - 256];
    endfunction

    function automatic void set_head(int s, bit [5:0] v);
        if (s < 256) m_near_hd[s] = v;
        else m_lvl_hd[s - 256] = v;
    endfunction

    function automatic void set_tail(int s, bit [5:0] v);
        if (s < 256) m_near_tl[s] = v;
        else m_lvl_tl[s - 256] = v;
    endfunction

    function automatic void list_append(int s, int e);
        bit [5:0] tl;
        tl = slot_tail(s);
        m_slot[e] = s;
        m_next[e] = htw_pkg::NIL;
        m_prev[e] = tl;
        if (tl < 32) m_next[tl] = e[5:0];
        else set_head(s, e[5:0]);
        set_tail(s, e[5:0]);
    endfunction

    function automatic void list_unlink(int e);
        int s;
        bit [5:0] p;
        bit [5:0] n;
        s = m_slot[e];
        p = m_prev[e];
        n = m_next[e];
        if (p < 32) m_next[p] = n;
        else set_head(s, n);
        if (n < 32) m_prev[n] = p;
        else set_tail(s, p);
    endfunction

    function automatic void place_timer(int e);
        bit [31:0] ex;
        int i;
        ex = m_expiry[e];
        if ((ex >> 8) == (m_now >> 8)) begin
            list_append(int'(ex & 255), e);
        end else begin
            for (i = 0; i < 3; i++) begin
                if ((ex >> (14 + 6 * i)) == (m_now >> (14 + 6 * i))) break;
            end
            list_append(256 + i * 64 + int'((ex >> (8 + 6 * i)) & 63), e);
        end
    endfunction

    function automatic void cascade_slot(int lvl, int idx);
        int s;
        int guard;
        bit [5:0] e;
        bit [5:0] nx;
        s = 256 + lvl * 64 + idx;
        e = slot_head(s);
        guard = 0;
        set_head(s, htw_pkg::NIL);
        set_tail(s, htw_pkg::NIL);
        while (e < 32 && guard < 32) begin
            nx = m_next[e];
            place_timer(int'(e));
            e = nx;
            guard++;
        end
    endfunction

    function automatic void advance_tick();
        bit [31:0] ct;
        bit [31:0] t;
        longint unsigned mask;
        int i;
        m_now = m_now + 32'd1;
        ct = m_now;
        if (ct == 0) begin
            cascade_slot(3, 0);
        end else begin
            mask = 256;
            t = ct >> 8;
            i = 0;
            while ((ct & (mask - 1)) == 0 && i < 4) begin
                if ((t & 63) != 0) begin
                    cascade_slot(i, int'(t & 63));
                    break;
                end
                mask = mask << 6;
                t = t >> 6;
                i++;
            end
        end
    endfunction

    function automatic void add_event(ref t_wheel_event evs[$], input logic [2:0] k,
                                      input int h, input logic [31:0] tg);
        t_wheel_event ev;
        ev.kind = k;
        ev.handle = h[4:0];
        ev.tag = tg;
        ev.now = '0;
        ev.last = 1'b0;
        evs.push_back(ev);
    endfunction

    function automatic void fire_slot(ref t_wheel_event evs[$]);
        int s;
        int guard;
        bit [5:0] e;
        bit [5:0] nx;
        s = int'(m_now & 255);
        e = m_near_hd[s];
        guard = 0;
        m_near_hd[s] = htw_pkg::NIL;
        m_near_tl[s] = htw_pkg::NIL;
        while (e < 32 && guard < 32 && evs.size() < 32) begin
            nx = m_next[e];
            m_armed[e] = 0;
            add_event(evs, htw_pkg::KIND_EXPIRED, int'(e), m_tag[e]);
            e = nx;
            guard++;
        end
    endfunction

    function automatic void predict_wheel(logic [1:0] op, logic [31:0] tg,
                                          logic [31:0] d, logic [4:0] h);
        t_wheel_event evs[$];
        int e;
        if (op == htw_pkg::OP_ADD) begin
            if (d == 0 || d[31]) begin
                add_event(evs, htw_pkg::KIND_EXPIRED, 0, tg);
            end else begin
                for (e = 0; e < 32; e++) begin
                    if (!m_armed[e]) break;
                end
                if (e >= 32) begin
                    add_event(evs, htw_pkg::KIND_FULL, 0, '0);
                end else begin
                    m_armed[e] = 1;
                    m_tag[e] = tg;
                    m_delay[e] = d;
                    m_expiry[e] = m_now + d;
                    place_timer(e);
                    add_event(evs, htw_pkg::KIND_ASSIGNED, e, tg);
                end
            end
        end else if (op == htw_pkg::OP_RESTART) begin
            if (!m_armed[h]) begin
                add_event(evs, htw_pkg::KIND_BAD, int'(h), '0);
            end else begin
                list_unlink(int'(h));
                m_expiry[h] = m_now + m_delay[h];
                place_timer(int'(h));
                add_event(evs, htw_pkg::KIND_ASSIGNED, int'(h), m_tag[h]);
            end
        end else if (op == htw_pkg::OP_TICK) begin
            fire_slot(evs);
            advance_tick();
            fire_slot(evs);
            add_event(evs, htw_pkg::KIND_DONE, 0, '0);
        end
        foreach (evs[k]) begin
            evs[k].now = m_now;
            evs[k].last = (k == evs.size() - 1);
            event_q.push_back(evs[k]);
        end
    endfunction

    function automatic void queue_cmd(logic [1:0] op, logic [31:0] tg, logic [31:0] d,
                                      logic [4:0] h);
        t_timer_cmd c;
        c.op = op;
        c.tag = tg;
        c.delay = d;
        c.handle = h;
        cmd_q.push_back(c);
    endfunction

    function automatic logic [31:0] rand_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 300);
        if (r < 80) return $urandom | 32'h8000_0000;
        if (r < 82) return '0;
        if (r < 86) return $urandom & 32'h7fff_ffff;
        return $urandom_range(256, 20000);
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int r;
        for (int s = 0; s < 256; s++) begin
            m_near_hd[s] = htw_pkg::NIL;
            m_near_tl[s] = htw_pkg::NIL;
            m_lvl_hd[s] = htw_pkg::NIL;
            m_lvl_tl[s] = htw_pkg::NIL;
        end
        for (int e = 0; e < 32; e++) begin
            m_next[e] = '0;
            m_prev[e] = '0;
            m_expiry[e] = '0;
            m_delay[e] = '0;
            m_tag[e] = '0;
            m_slot[e] = 0;
            m_armed[e] = 0;
        end
        m_now = '0;

        queue_cmd(htw_pkg::OP_RESTART, '0, '0, 5'd0);
        queue_cmd(htw_pkg::OP_ADD, 32'h0, 32'h0, 5'd0);
        queue_cmd(htw_pkg::OP_ADD, 32'hffff_ffff, 32'h8000_0000, 5'd31);
        queue_cmd(htw_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 5'd0);
        queue_cmd(htw_pkg::OP_ADD, 32'h1234_5678, 32'h7fff_ffff, 5'd0);
        queue_cmd(htw_pkg::OP_ADD, 32'haaaa_5555, 32'd1, 5'd0);
        queue_cmd(htw_pkg::OP_ADD, 32'h5555_aaaa, 32'd300, 5'd0);
        queue_cmd(htw_pkg::OP_ADD, 32'h0bad_cafe, 32'd16389, 5'd0);
        queue_cmd(htw_pkg::OP_RESTART, '0, '0, 5'd0);
        queue_cmd(htw_pkg::OP_RESTART, '0, '0, 5'd1);
        queue_cmd(htw_pkg::OP_RESTART, '0, '0, 5'd31);
        queue_cmd(OP_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff, 5'd31);
        queue_cmd(htw_pkg::OP_TICK, '0, '0, 5'd0);
        queue_cmd(htw_pkg::OP_TICK, '0, '0, 5'd0);
        for (int k = 0; k < 30; k++) begin
            queue_cmd(htw_pkg::OP_ADD, $urandom, $urandom_range(1, 6), 5'd0);
        end
        for (int k = 0; k < 8; k++) queue_cmd(htw_pkg::OP_TICK, '0, '0, 5'd0);

        for (int k = 0; k < 100; k++) begin
            r = $urandom_range(0, 99);
            if (k == 50) begin
                for (int j = 0; j < 120; j++) queue_cmd(htw_pkg::OP_TICK, '0, '0, 5'd0);
            end
            if (r < 45) begin
                queue_cmd(htw_pkg::OP_TICK, $urandom, $urandom, 5'($urandom));
            end else if (r < 80) begin
                queue_cmd(htw_pkg::OP_ADD, $urandom, rand_delay(), 5'($urandom));
            end else if (r < 97) begin
                queue_cmd(htw_pkg::OP_RESTART, $urandom, $urandom, 5'($urandom));
            end else begin
                queue_cmd(OP_UNKNOWN, $urandom, $urandom, 5'($urandom));
            end
        end
        fill_done = 1;

        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        wait (fill_done && cmd_q.size() == 0 && !start && event_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && event_q.size() == 0) begin
            $display("hierarchical_timing_wheel test passed");
        end else begin
            $display("hierarchical_timing_wheel test failed");
        end
        $finish;
    end

    initial begin
        start = 0;
        i_operation = '0;
        i_tag = '0;
        i_delay = '0;
        i_handle = '0;
    end

    always @(posedge i_clk) begin
        t_timer_cmd c;
        if (!i_rst_n) begin
            start <= 0;
        end else if (start && !busy) begin
            predict_wheel(i_operation, i_tag, i_delay, i_handle);
            gap = rand_gap();
            if (gap == 0 && cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                i_operation <= c.op;
                i_tag <= c.tag;
                i_delay <= c.delay;
                i_handle <= c.handle;
            end else begin
                start <= 0;
            end
        end else if (!start) begin
            if (gap > 0) begin
                gap--;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                i_operation <= c.op;
                i_tag <= c.tag;
                i_delay <= c.delay;
                i_handle <= c.handle;
                start <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_wheel_event ev;
        if (i_rst_n && o_valid) begin
            if (event_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d handle=%0d tag=%h now=%h last=%0d",
                         $time, o_kind, o_handle_res, o_tag_res, o_now, o_last);
                errors++;
            end else begin
                ev = event_q.pop_front();
                if (o_kind !== ev.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, ev.kind, o_kind);
                    errors++;
                end
                if (o_handle_res !== ev.handle) begin
                    $display("%0t: handle expected %0d actual %0d", $time, ev.handle,
                             o_handle_res);
                    errors++;
                end
                if (o_tag_res !== ev.tag) begin
                    $display("%0t: tag expected %h actual %h", $time, ev.tag, o_tag_res);
                    errors++;
                end
                if (o_now !== ev.now) begin
                    $display("%0t: now expected %h actual %h", $time, ev.now, o_now);
                    errors++;
                end
                if (o_last !== ev.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, ev.last, o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 600000) begin
            $display("hierarchical_timing_wheel test failed");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+design
design/htw_pkg.sv
design/htw_ram.sv
design/htw_slot_calc.sv
design/hierarchical_timing_wheel.sv
tb/tb_top.sv
